>>> rtl/keyframe_linear_interpolator_assert.svh
// ----------------------------------------------------------------------------
// Keyframe linear interpolator assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every rising edge outside reset.
`define KLI_ASSERT_HOLDS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("keyframe_linear_interpolator: assertion failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyframe_linear_interpolator: assertion failed");

`else

`define KLI_ASSERT_HOLDS(label, clk, rst_n, prop)
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/kli_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator package
// Shared types and constants for the sequencer and the divider cell chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kli_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_FIRST,
    S_CHK_LAST,
    S_SEARCH,
    S_RD_A,
    S_RD_B,
    S_LAUNCH,
    S_DIV,
    S_MUL,
    S_SUM,
    S_FIN
  } kli_state_t;

  // One restoring-division step travels down the chain in this record.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] span;
    logic [FRAC_W-1:0] quo;
  } kli_div_stage_t;

endpackage

`default_nettype wire

>>> rtl/keyframe_linear_interpolator.sv
// ----------------------------------------------------------------------------
// Keyframe linear interpolator
// Keyframe table with upper-bound search and piecewise linear sampling.
// ----------------------------------------------------------------------------
// The input channel carries one item per handshake. A write item (command 0)
// stores time_req and key_value in slot key_index; slots at or beyond
// KEYS_MAX are ignored. A sample item (command 1) returns one result item on
// the output channel with the Q16.16 value of the curve at time_req. The
// configuration channel sets key_count, the number of keys in use; write it
// only while the block is idle.
// A sample that hits an end of the table or an empty table finishes without
// a search. An interior sample runs s binary search probes, where s is at
// most ceil(log2(n + 1)), 7 for 64 keys. Its time is set by the single read
// port of the key memory, one probe per cycle, and by the row of FRAC_W
// divider cells that yields the fraction.
// One item is worked on at a time; in_ready is high only between samples.
// The result sits in an output register, so the next item is accepted while
// an earlier result waits; a new result waits in the sequencer until the
// output register frees up, which backs up the input channel.
// Reset clears key_count and all control state. The key memory is not
// cleared; slots must be written before they are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keyframe_linear_interpolator_assert.svh"

module keyframe_linear_interpolator
  import kli_pkg::*;
#(
  parameter int KEYS_MAX = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     in_command,
  input  wire logic        [5:0]        in_key_index,
  input  wire logic signed [DATA_W-1:0] in_time_req,
  input  wire logic signed [DATA_W-1:0] in_key_value,
  output      logic                     out_valid,
  input  wire logic                     out_ready,
  output      logic signed [DATA_W-1:0] out_sampled_value,
  input  wire logic                     cfg_valid,
  output      logic                     cfg_ready,
  input  wire logic        [6:0]        cfg_key_count
);

  localparam int AW    = $clog2(KEYS_MAX);
  localparam int CNT_W = $clog2(KEYS_MAX + 1);
  localparam int SLOT_W = 6;

  // Configuration register.
  logic [6:0] key_count_r;

  // Key memory, one read port with registered data.
  logic signed [DATA_W-1:0] key_times_mem  [KEYS_MAX];
  logic signed [DATA_W-1:0] key_values_mem [KEYS_MAX];
  logic signed [DATA_W-1:0] rd_time_r;
  logic signed [DATA_W-1:0] rd_value_r;
  logic        [AW-1:0]     rd_addr;
  logic                     mem_we;
  logic [AW+SLOT_W-1:0]     slot_ext;
  logic [AW-1:0]            wr_addr;

  // Sequencer state.
  kli_state_t state_r, state_nxt;
  logic [CNT_W-1:0] n_w;
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] right_r, right_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic signed [DATA_W-1:0] ta_r, ta_nxt;
  logic signed [DATA_W-1:0] va_r, va_nxt;
  logic signed [DATA_W:0]   diff_r, diff_nxt;
  logic signed [DATA_W:0]   span_r, span_nxt;
  logic signed [DATA_W:0]   delta_r, delta_nxt;
  logic                     frac_zero_r, frac_zero_nxt;
  logic                     frac_sat_r, frac_sat_nxt;
  logic [FRAC_W-1:0]        frac_r, frac_nxt;
  logic [47:0]              prod_r, prod_nxt;
  logic signed [DATA_W-1:0] result_r, result_nxt;

  // Search step helpers.
  logic [CNT_W-1:0] half_w;
  logic [CNT_W-1:0] step_lo;
  logic [CNT_W-1:0] step_len;
  logic [CNT_W-1:0] probe_w;
  logic [CNT_W-1:0] clamp_w;

  // Output register.
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_data_r;
  logic                     out_load;

  kli_div_stage_t div_in;
  kli_div_stage_t div_out;
  logic signed [FRAC_W:0] frac_s;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_count_r <= cfg_key_count;
    end
  end

  // A count above the table depth acts as the depth.
  assign n_w = (32'(key_count_r) > 32'(KEYS_MAX)) ? CNT_W'(KEYS_MAX) : CNT_W'(key_count_r);

  // Writes land only while idle, so they never meet a read of the same sample.
  assign slot_ext = (AW + SLOT_W)'(in_key_index);
  assign wr_addr  = slot_ext[AW-1:0];
  assign mem_we   = in_valid && in_ready && (in_command == CMD_WRITE) &&
                    (32'(in_key_index) < 32'(KEYS_MAX));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_times_mem[wr_addr]  <= in_time_req;
      key_values_mem[wr_addr] <= in_key_value;
    end
    rd_time_r  <= key_times_mem[rd_addr];
    rd_value_r <= key_values_mem[rd_addr];
  end

  // One probe of the upper-bound search, using the data read last cycle.
  always_comb begin
    half_w = len_r >> 1;
    if (!(t_r < rd_time_r)) begin
      step_lo  = lo_r + half_w + CNT_W'(1);
      step_len = len_r - half_w - CNT_W'(1);
    end else begin
      step_lo  = lo_r;
      step_len = half_w;
    end
    probe_w = step_lo + (step_len >> 1);
    if (step_lo == '0) begin
      clamp_w = CNT_W'(1);
    end else if (step_lo > n_w - CNT_W'(1)) begin
      clamp_w = n_w - CNT_W'(1);
    end else begin
      clamp_w = step_lo;
    end
  end

  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    len_nxt       = len_r;
    right_nxt     = right_r;
    t_nxt         = t_r;
    ta_nxt        = ta_r;
    va_nxt        = va_r;
    diff_nxt      = diff_r;
    span_nxt      = span_r;
    delta_nxt     = delta_r;
    frac_zero_nxt = frac_zero_r;
    frac_sat_nxt  = frac_sat_r;
    frac_nxt      = frac_r;
    prod_nxt      = prod_r;
    result_nxt    = result_r;
    rd_addr       = '0;
    div_in        = '0;

    unique case (state_r)
      S_IDLE: begin
        t_nxt = in_time_req;
        if (in_valid && (in_command == CMD_SAMPLE)) begin
          if (n_w == '0) begin
            result_nxt = '0;
            state_nxt  = S_FIN;
          end else begin
            state_nxt = S_CHK_FIRST;
          end
        end
      end
      S_CHK_FIRST: begin
        if (t_r <= rd_time_r) begin
          result_nxt = rd_value_r;
          state_nxt  = S_FIN;
        end else begin
          rd_addr   = AW'(n_w - CNT_W'(1));
          state_nxt = S_CHK_LAST;
        end
      end
      S_CHK_LAST: begin
        if (t_r >= rd_time_r) begin
          result_nxt = rd_value_r;
          state_nxt  = S_FIN;
        end else begin
          lo_nxt    = '0;
          len_nxt   = n_w;
          rd_addr   = AW'(n_w >> 1);
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        lo_nxt  = step_lo;
        len_nxt = step_len;
        if (step_len != '0) begin
          rd_addr = AW'(probe_w);
        end else begin
          right_nxt = clamp_w;
          rd_addr   = AW'(clamp_w - CNT_W'(1));
          state_nxt = S_RD_A;
        end
      end
      S_RD_A: begin
        ta_nxt    = rd_time_r;
        va_nxt    = rd_value_r;
        rd_addr   = AW'(right_r);
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        diff_nxt  = {t_r[DATA_W-1], t_r} - {ta_r[DATA_W-1], ta_r};
        span_nxt  = {rd_time_r[DATA_W-1], rd_time_r} - {ta_r[DATA_W-1], ta_r};
        delta_nxt = {rd_value_r[DATA_W-1], rd_value_r} - {va_r[DATA_W-1], va_r};
        state_nxt = S_LAUNCH;
      end
      S_LAUNCH: begin
        // A key that is not later than its left neighbor, or a time not past
        // the left key, gives a zero fraction; a full span saturates.
        frac_zero_nxt = (span_r <= 0) || (diff_r <= 0);
        frac_sat_nxt  = (diff_r >= span_r);
        div_in.valid  = 1'b1;
        div_in.rem    = diff_r[DATA_W-1:0];
        div_in.span   = span_r[DATA_W-1:0];
        div_in.quo    = '0;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (div_out.valid) begin
          if (frac_zero_r) begin
            frac_nxt = '0;
          end else if (frac_sat_r) begin
            frac_nxt = '1;
          end else begin
            frac_nxt = div_out.quo;
          end
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = 48'(delta_r * frac_s);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        // The arithmetic shift of the product floors toward minus infinity.
        result_nxt = va_r + prod_r[47:16];
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign frac_s = {1'b0, frac_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    len_r       <= len_nxt;
    right_r     <= right_nxt;
    t_r         <= t_nxt;
    ta_r        <= ta_nxt;
    va_r        <= va_nxt;
    diff_r      <= diff_nxt;
    span_r      <= span_nxt;
    delta_r     <= delta_nxt;
    frac_zero_r <= frac_zero_nxt;
    frac_sat_r  <= frac_sat_nxt;
    frac_r      <= frac_nxt;
    prod_r      <= prod_nxt;
    result_r    <= result_nxt;
  end

  kli_div_chain u_div_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .stage_i (div_in),
    .stage_o (div_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= result_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sampled_value = out_data_r;

  // A fraction only leaves the cell chain while the sequencer waits for it.
  `KLI_ASSERT_HOLDS(a_div_out_in_div, clk, rst_n, !div_out.valid || (state_r == S_DIV))
  // A pending result holds the sequencer until the output register frees up.
  `KLI_ASSERT_NEXT(a_fin_waits, clk, rst_n,
                   (state_r == S_FIN) && out_valid_r && !out_ready, state_r == S_FIN)
  // Each search probe was issued with a nonempty range.
  `KLI_ASSERT_HOLDS(a_search_len, clk, rst_n, (state_r != S_SEARCH) || (len_r != '0))
  // The right key of the bracket lies between 1 and n-1.
  `KLI_ASSERT_HOLDS(a_right_range, clk, rst_n,
                    (state_r != S_RD_A) || ((right_r != '0) && (right_r < n_w)))

endmodule

`default_nettype wire

>>> rtl/kli_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: produces one quotient bit and passes on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kli_div_cell
  import kli_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kli_div_stage_t stage_i,
  output kli_div_stage_t      stage_o
);

  kli_div_stage_t     stage_r;
  logic [DATA_W:0]    shifted;
  logic [DATA_W:0]    trial;
  logic               take;

  // The remainder stays below the divisor, so the shifted value fits one more bit.
  assign shifted = {stage_i.rem, 1'b0};
  assign trial   = shifted - {1'b0, stage_i.span};
  assign take    = (shifted >= {1'b0, stage_i.span});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_i.valid;
    end
    stage_r.span <= stage_i.span;
    stage_r.rem  <= take ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
    stage_r.quo  <= {stage_i.quo[FRAC_W-2:0], take};
  end

  assign stage_o = stage_r;

endmodule

`default_nettype wire

>>> rtl/kli_div_chain.sv
// ----------------------------------------------------------------------------
// Divider cell chain
// A row of registered division cells, one per fraction bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kli_div_chain
  import kli_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kli_div_stage_t stage_i,
  output kli_div_stage_t      stage_o
);

  kli_div_stage_t link [0:FRAC_W];

  assign link[0] = stage_i;

  for (genvar g = 0; g < FRAC_W; g++) begin : g_cell
    kli_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .stage_i (link[g]),
      .stage_o (link[g+1])
    );
  end

  assign stage_o = link[FRAC_W];

endmodule

`default_nettype wire
